// File: design/ntl_pkg.sv
package ntl_pkg;

   localparam int KEY_W    = 64;
   localparam int FUNC_W   = 2;
   localparam int EIDX_W   = 10;
   localparam int RIDX_W   = 10;
   localparam int COUNT_W  = 11;
   localparam int STATUS_W = 2;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 88;

   localparam logic [FUNC_W-1:0] FN_PRELOAD = 2'd0;
   localparam logic [FUNC_W-1:0] FN_FIND    = 2'd1;
   localparam logic [FUNC_W-1:0] FN_INSERT  = 2'd2;
   localparam logic [FUNC_W-1:0] FN_READ    = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_RDWAIT = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

endpackage

// File: design/ntl_ram.sv
module ntl_ram #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [ntl_pkg::KEY_W-1:0]   wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [ntl_pkg::KEY_W-1:0]   rd_data
);
   import ntl_pkg::*;

   logic [KEY_W-1:0] mem [DEPTH];
   logic [KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/name_table_lookup_or_insert.sv
// Channel   Dir  tdata fields (low bit up)                        tuser
// req_      in   key_name[63:0], entry_index[73:64], zero pad      func[1:0]
// rsp_      out  result_index[9:0], hit[10], read_name[74:11],     status[1:0]
//                added_later[75], entry_count[86:76], zero pad
//
// Preload and an out-of-range read go from idle straight to the done state; an in-range
// read passes through a read-wait state for the stored name before the done state.
// Find and find-or-insert compare one stored entry per cycle through the single read
// port of the name store, until a match or the end of the stored entries.
// Reset clears the counts and the sequencer; the name store is not cleared.
// Input is taken only while idle; a waiting result does not block the next input.
module name_table_lookup_or_insert #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ntl_pkg::REQ_DATA_W-1:0]    req_tdata,  // key_name, entry_index
   input  logic [ntl_pkg::FUNC_W-1:0]        req_tuser,  // func
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ntl_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // result_index, hit, read_name,
                                                         // added_later, entry_count
   output logic [ntl_pkg::STATUS_W-1:0]      rsp_tuser   // status
);
   import ntl_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int CW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int IW    = (IDX_W > RIDX_W) ? IDX_W : RIDX_W;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

   state_type            state_ff, state_in;
   logic [FUNC_W-1:0]    func_ff, func_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [CNT_W-1:0]     top_ff, top_in;
   logic [CNT_W-1:0]     known_ff, known_in;
   logic [CNT_W-1:0]     scan_ff, scan_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]     cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]     res_idx_ff, res_idx_in;
   logic                 res_hit_ff, res_hit_in;
   logic [KEY_W-1:0]     res_name_ff, res_name_in;
   logic                 res_later_ff, res_later_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [STATUS_W-1:0]  rsp_tuser_ff, rsp_tuser_in;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic [KEY_W-1:0]     rd_data;

   logic [EIDX_W-1:0]    req_eidx;
   logic [CW-1:0]        eidx_wide;
   logic [CW-1:0]        top_wide;
   logic [IW-1:0]        res_idx_wide;
   logic                 match;
   logic                 room;

   ntl_ram #(
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (key_in),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready   = (state_ff == ST_IDLE);
   assign req_eidx     = req_tdata[KEY_W+EIDX_W-1:KEY_W];
   assign eidx_wide    = CW'(req_eidx);
   assign top_wide     = CW'(top_ff);
   assign res_idx_wide = IW'(res_idx_ff);
   assign match        = cmp_vld_ff && (rd_data == key_ff);
   assign room         = (top_ff < DEPTH_C);

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      top_in        = top_ff;
      known_in      = known_ff;
      scan_in       = scan_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      res_idx_in    = res_idx_ff;
      res_hit_in    = res_hit_ff;
      res_name_in   = res_name_ff;
      res_later_in  = res_later_ff;
      res_status_in = res_status_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      wr_en         = 1'b0;
      wr_addr       = top_ff[IDX_W-1:0];
      rd_en         = 1'b0;
      rd_addr       = scan_ff[IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               func_in       = req_tuser;
               key_in        = req_tdata[KEY_W-1:0];
               res_idx_in    = '0;
               res_hit_in    = 1'b0;
               res_name_in   = '0;
               res_later_in  = 1'b0;
               res_status_in = STAT_OK;
               case (req_tuser)
                  FN_PRELOAD: begin
                     if (room) begin
                        wr_en      = 1'b1;
                        res_idx_in = top_ff[IDX_W-1:0];
                        top_in     = top_ff + 1'b1;
                        known_in   = top_ff + 1'b1;
                     end else begin
                        res_status_in = STAT_FULL;
                     end
                     state_in = ST_DONE;
                  end
                  FN_READ: begin
                     if (eidx_wide < top_wide) begin
                        rd_en        = 1'b1;
                        rd_addr      = IDX_W'(req_eidx);
                        res_idx_in   = IDX_W'(req_eidx);
                        res_later_in = (eidx_wide >= CW'(known_ff));
                        state_in     = ST_RDWAIT;
                     end else begin
                        res_status_in = STAT_RANGE;
                        state_in      = ST_DONE;
                     end
                  end
                  default: begin
                     scan_in  = '0;
                     state_in = ST_SCAN;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (match) begin
               res_idx_in   = cmp_idx_ff;
               res_hit_in   = 1'b1;
               res_later_in = (CNT_W'(cmp_idx_ff) >= known_ff);
               state_in     = ST_DONE;
            end else if (scan_ff == top_ff) begin
               if (func_ff == FN_INSERT) begin
                  if (room) begin
                     wr_en        = 1'b1;
                     res_idx_in   = top_ff[IDX_W-1:0];
                     res_later_in = (top_ff >= known_ff);
                     top_in       = top_ff + 1'b1;
                  end else begin
                     res_status_in = STAT_FULL;
                  end
               end
               state_in = ST_DONE;
            end else begin
               rd_en      = 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = scan_ff[IDX_W-1:0];
               scan_in    = scan_ff + 1'b1;
            end
         end
         ST_RDWAIT: begin
            res_name_in = rd_data;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {1'b0, top_wide[COUNT_W-1:0], res_later_ff, res_name_ff,
                                res_hit_ff, res_idx_wide[RIDX_W-1:0]};
               rsp_tuser_in  = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         top_ff        <= '0;
         known_ff      <= '0;
         cmp_vld_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         top_ff        <= top_in;
         known_ff      <= known_in;
         cmp_vld_ff    <= cmp_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      key_ff        <= key_in;
      scan_ff       <= scan_in;
      cmp_idx_ff    <= cmp_idx_in;
      res_idx_ff    <= res_idx_in;
      res_hit_ff    <= res_hit_in;
      res_name_ff   <= res_name_in;
      res_later_ff  <= res_later_in;
      res_status_ff <= res_status_in;
      rsp_tdata_ff  <= rsp_tdata_in;
      rsp_tuser_ff  <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

// File: sim/tb_name_table_lookup_or_insert.sv
module tb_name_table_lookup_or_insert;
   timeunit 1ns;
   timeprecision 1ps;

   import ntl_pkg::*;

   localparam int TBL_DEPTH  = 1024;
   localparam int TBL_IDX_W  = $clog2(TBL_DEPTH);
   localparam int LIMIT      = 3_000_000;
   localparam int HOLD_LEN   = 400;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [KEY_W-1:0]  key;
      logic [EIDX_W-1:0] eidx;
   } req_type;

   typedef struct packed {
      logic [RIDX_W-1:0]   ridx;
      logic                hit;
      logic [KEY_W-1:0]    rname;
      logic                later;
      logic [COUNT_W-1:0]  count;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      req_type req;
      logic    fixed;
      rsp_type want;
   } row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_W-1:0]     req_tdata = '0;
   logic [FUNC_W-1:0]         req_tuser = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]     rsp_tdata;
   logic [STATUS_W-1:0]       rsp_tuser;

   logic [KEY_W-1:0] tbl_names [0:TBL_DEPTH-1];
   int               tbl_count = 0;
   int               tbl_mark = 0;
   rsp_type          due_rsps [$];
   row_type          dir_rows [$];
   int               errors = 0;
   int               cycle_count = 0;
   int               tx_idle = 8;
   int               rx_idle = 71;
   bit               hold_req = 1'b0;
   int               hold_left = 0;

   name_table_lookup_or_insert #(
      .TABLE_DEPTH(TBL_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   // Applies one operation to the table copy and returns the result it gives.
   function automatic rsp_type apply_to_table(input req_type r);
      rsp_type o;
      int      pos;
      o = '0;
      pos = -1;
      if (r.func == FN_FIND || r.func == FN_INSERT) begin
         for (int i = 0; i < tbl_count && pos < 0; i++) begin
            if (tbl_names[TBL_IDX_W'(i)] == r.key) begin
               pos = i;
            end
         end
      end
      case (r.func)
         FN_PRELOAD: begin
            if (tbl_count < TBL_DEPTH) begin
               tbl_names[TBL_IDX_W'(tbl_count)] = r.key;
               o.ridx = RIDX_W'(tbl_count);
               tbl_count++;
               tbl_mark = tbl_count;
            end else begin
               o.status = STAT_FULL;
            end
         end
         FN_FIND, FN_INSERT: begin
            if (pos >= 0) begin
               o.ridx = RIDX_W'(pos);
               o.hit = 1'b1;
               o.later = (pos >= tbl_mark);
            end else if (r.func == FN_INSERT) begin
               if (tbl_count < TBL_DEPTH) begin
                  tbl_names[TBL_IDX_W'(tbl_count)] = r.key;
                  o.ridx = RIDX_W'(tbl_count);
                  o.later = (tbl_count >= tbl_mark);
                  tbl_count++;
               end else begin
                  o.status = STAT_FULL;
               end
            end
         end
         default: begin
            if (r.eidx < tbl_count) begin
               o.ridx = r.eidx;
               o.rname = tbl_names[r.eidx];
               o.later = (r.eidx >= tbl_mark);
            end else begin
               o.status = STAT_RANGE;
            end
         end
      endcase
      o.count = COUNT_W'(tbl_count);
      return o;
   endfunction

   // Most keys are taken from the table or are one bit away from a stored key,
   // so that finds and inserts hit often and duplicates get preloaded.
   function automatic req_type next_item();
      req_type r;
      int      pick;
      pick = $urandom_range(99);
      if (pick < 15) begin
         r.func = FN_PRELOAD;
      end else if (pick < 45) begin
         r.func = FN_FIND;
      end else if (pick < 80) begin
         r.func = FN_INSERT;
      end else begin
         r.func = FN_READ;
      end
      r.key = {$urandom, $urandom};
      pick = $urandom_range(99);
      if (tbl_count != 0 && pick < 60) begin
         r.key = tbl_names[TBL_IDX_W'($urandom_range(tbl_count - 1))];
      end else if (tbl_count != 0 && pick < 70) begin
         r.key = tbl_names[TBL_IDX_W'($urandom_range(tbl_count - 1))]
                 ^ (64'd1 << $urandom_range(63));
      end
      r.eidx = EIDX_W'($urandom_range(TBL_DEPTH - 1));
      if (r.func == FN_READ && tbl_count != 0 && $urandom_range(99) < 75) begin
         r.eidx = EIDX_W'($urandom_range(tbl_count - 1));
      end
      return r;
   endfunction

   function automatic rsp_type mk_rsp(input logic [RIDX_W-1:0] ridx, input logic hit,
                                      input logic [KEY_W-1:0] rname, input logic later,
                                      input logic [COUNT_W-1:0] count,
                                      input logic [STATUS_W-1:0] status);
      rsp_type o;
      o.ridx = ridx;
      o.hit = hit;
      o.rname = rname;
      o.later = later;
      o.count = count;
      o.status = status;
      return o;
   endfunction

   function automatic row_type mk_row(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                                      input logic [EIDX_W-1:0] e, input logic fixed,
                                      input rsp_type want);
      row_type w;
      w.req.func = f;
      w.req.key = k;
      w.req.eidx = e;
      w.fixed = fixed;
      w.want = want;
      return w;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_item(input req_type r, input logic fixed, input rsp_type fixed_rsp);
      rsp_type p;
      while ($urandom_range(99) < tx_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, r.eidx, r.key};
      req_tuser <= r.func;
      do begin
         @(posedge clock);
      end while (!req_tready);
      p = apply_to_table(r);
      due_rsps.push_back(fixed ? fixed_rsp : p);
      @(negedge clock);
   endtask

   task automatic drain_table_ops();
      req_tvalid <= 1'b0;
      while (due_rsps.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic cmp_field(input string what, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch: expected %h, got %h", $time, what, want, got);
         errors++;
      end
   endtask

   initial begin
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_LEN;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle);
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ridx = rsp_tdata[9:0];
         got.hit = rsp_tdata[10];
         got.rname = rsp_tdata[74:11];
         got.later = rsp_tdata[75];
         got.count = rsp_tdata[86:76];
         got.status = rsp_tuser;
         if (due_rsps.size() == 0) begin
            $display("%0t ns: unexpected result: expected none, got %h", $time, got);
            errors++;
         end else begin
            want = due_rsps.pop_front();
            cmp_field("result_index", 64'(want.ridx), 64'(got.ridx));
            cmp_field("hit", 64'(want.hit), 64'(got.hit));
            cmp_field("read_name", want.rname, got.rname);
            cmp_field("added_later", 64'(want.later), 64'(got.later));
            cmp_field("entry_count", 64'(want.count), 64'(got.count));
            cmp_field("status", 64'(want.status), 64'(got.status));
         end
      end
   end

   initial begin
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      dir_rows.push_back(mk_row(FN_READ, 64'd0, 10'd0, 1'b1,
                                mk_rsp(10'd0, 1'b0, 64'd0, 1'b0, 11'd0, STAT_RANGE)));
      dir_rows.push_back(mk_row(FN_FIND, '1, 10'd0, 1'b1,
                                mk_rsp(10'd0, 1'b0, 64'd0, 1'b0, 11'd0, STAT_OK)));
      dir_rows.push_back(mk_row(FN_INSERT, 64'd0, 10'd0, 1'b1,
                                mk_rsp(10'd0, 1'b0, 64'd0, 1'b1, 11'd1, STAT_OK)));
      dir_rows.push_back(mk_row(FN_PRELOAD, '1, 10'd1023, 1'b1,
                                mk_rsp(10'd1, 1'b0, 64'd0, 1'b0, 11'd2, STAT_OK)));
      dir_rows.push_back(mk_row(FN_FIND, '1, 10'd0, 1'b0, '0));
      dir_rows.push_back(mk_row(FN_FIND, 64'd0, 10'd0, 1'b0, '0));
      dir_rows.push_back(mk_row(FN_INSERT, '1, 10'd0, 1'b0, '0));
      dir_rows.push_back(mk_row(FN_INSERT, 64'h0123456789ABCDEF, 10'd0, 1'b0, '0));
      dir_rows.push_back(mk_row(FN_PRELOAD, 64'h0123456789ABCDEF, 10'd0, 1'b0, '0));
      dir_rows.push_back(mk_row(FN_FIND, 64'h0123456789ABCDEF, 10'd0, 1'b0, '0));
      dir_rows.push_back(mk_row(FN_READ, '1, 10'd3, 1'b0, '0));
      dir_rows.push_back(mk_row(FN_INSERT, 64'h8000000000000000, 10'd0, 1'b0, '0));
      dir_rows.push_back(mk_row(FN_READ, 64'd0, 10'd4, 1'b0, '0));
      dir_rows.push_back(mk_row(FN_READ, '1, 10'd1023, 1'b1,
                                mk_rsp(10'd0, 1'b0, 64'd0, 1'b0, 11'd5, STAT_RANGE)));
      dir_rows.push_back(mk_row(FN_READ, 64'd0, 10'd5, 1'b1,
                                mk_rsp(10'd0, 1'b0, 64'd0, 1'b0, 11'd5, STAT_RANGE)));
      dir_rows.push_back(mk_row(FN_FIND, 64'hFFFFFFFFFFFFFFFE, 10'd1023, 1'b0, '0));
      dir_rows.push_back(mk_row(FN_INSERT, 64'hFEDCBA9876543210, 10'd512, 1'b0, '0));
      dir_rows.push_back(mk_row(FN_READ, '1, 10'd0, 1'b0, '0));
      dir_rows.push_back(mk_row(FN_READ, 64'd0, 10'd1, 1'b0, '0));
      dir_rows.push_back(mk_row(FN_PRELOAD, 64'h0000000000000001, 10'd0, 1'b0, '0));
      dir_rows.push_back(mk_row(FN_FIND, 64'h8000000000000000, 10'd0, 1'b0, '0));
      dir_rows.push_back(mk_row(FN_READ, 64'd0, 10'd5, 1'b0, '0));

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      tx_idle = 8;
      rx_idle = 71;
      foreach (dir_rows[n]) begin
         send_item(dir_rows[n].req, dir_rows[n].fixed, dir_rows[n].want);
      end
      for (int n = 0; n < 190; n++) begin
         if (n == 40) begin
            hold_req = 1'b1;
         end
         send_item(next_item(), 1'b0, '0);
      end
      drain_table_ops();

      tx_idle = 71;
      rx_idle = 8;
      for (int n = 0; n < 190; n++) begin
         send_item(next_item(), 1'b0, '0);
      end
      drain_table_ops();

      tx_idle = 0;
      rx_idle = 0;
      for (int n = 0; n < 150; n++) begin
         send_item(next_item(), 1'b0, '0);
      end
      for (int n = 0; n < 30; n++) begin
         send_item(next_item(), 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      while (due_rsps.size() != 0) begin
         @(posedge clock);
      end
      repeat (40) @(posedge clock);
      if (errors == 0 && due_rsps.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
